FILE: hdl/pls_pkg.sv
// shared constants, types and helpers for the positional list store
// no dependencies
`timescale 1ns / 1ps

package pls_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int POS_W = 5;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef enum logic [2:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_AT   = 3'd2,
		OP_REM_HEAD = 3'd3,
		OP_REM_TAIL = 3'd4,
		OP_REM_AT   = 3'd5,
		OP_SEARCH   = 3'd6,
		OP_GET      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_req;
		logic scan_done;
	} sts_t;

	// 32-bit port word into stored width, sign kept
	function automatic data_t to_data(input logic signed [31:0] v);
		return data_t'(v);
	endfunction

	// stored word back to the 32-bit port, sign kept
	function automatic logic signed [31:0] from_data(input data_t d);
		return 32'(d);
	endfunction

endpackage

FILE: hdl/pls_ctrl.sv
// sequencing state machine of the positional list store
// depends on pls_pkg
`timescale 1ns / 1ps

module pls_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pls_pkg::sts_t sts,
	output pls_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = sts.scan_req ? S_SCAN : S_RESP;
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_RESP);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.scan = (state_q == S_SCAN);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted beat did not make the block busy");

endmodule

FILE: hdl/pls_dp.sv
// entry row, count and result registers of the positional list store
// depends on pls_pkg
`timescale 1ns / 1ps

module pls_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pls_pkg::cmd_t       cmd,
	output pls_pkg::sts_t       sts,
	input  logic [2:0]          op,
	input  logic signed [31:0]  value,
	input  logic [4:0]          position,
	output logic signed [31:0]  result_value,
	output logic [3:0]          found_position,
	output logic [1:0]          status,
	output logic [4:0]          length,
	output logic                is_empty
);

	localparam int CAP   = pls_pkg::CAPACITY;
	localparam int IDX_W = pls_pkg::IDX_W;
	localparam int CNT_W = pls_pkg::CNT_W;
	localparam int CMP_W = pls_pkg::CMP_W;

	pls_pkg::op_t     op_q;
	pls_pkg::data_t   value_q;
	logic [4:0]       pos_q;
	pls_pkg::data_t   entries_q [CAP];
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;

	logic signed [31:0] rv_q;
	logic [3:0]         fpos_q;
	pls_pkg::status_t   st_q;

	logic [CMP_W-1:0] cnt_ext, eff_pos;
	logic [IDX_W-1:0] rd_idx;
	pls_pkg::data_t   rd_data;
	pls_pkg::data_t   up_src [CAP];
	pls_pkg::data_t   dn_src [CAP];
	logic             pos_ok_ins, pos_ok_rd, full, hit, is_ins, is_rem;

	assign cnt_ext = CMP_W'(count_q);

	always_comb begin
		case (op_q)
			pls_pkg::OP_INS_HEAD: eff_pos = '0;
			pls_pkg::OP_REM_HEAD: eff_pos = '0;
			pls_pkg::OP_INS_TAIL: eff_pos = cnt_ext;
			pls_pkg::OP_REM_TAIL: eff_pos = cnt_ext - CMP_W'(1);
			default:              eff_pos = CMP_W'(pos_q);
		endcase
	end

	assign is_ins = (op_q == pls_pkg::OP_INS_HEAD) || (op_q == pls_pkg::OP_INS_TAIL)
		|| (op_q == pls_pkg::OP_INS_AT);
	assign is_rem = (op_q == pls_pkg::OP_REM_HEAD) || (op_q == pls_pkg::OP_REM_TAIL)
		|| (op_q == pls_pkg::OP_REM_AT);

	// single read port, scan index or operation position
	assign rd_idx  = cmd.scan ? idx_q : eff_pos[IDX_W-1:0];
	assign rd_data = entries_q[rd_idx];

	assign pos_ok_ins = (eff_pos <= cnt_ext);
	assign pos_ok_rd  = (eff_pos < cnt_ext);
	assign full       = (count_q == CNT_W'(CAP));
	assign hit        = (rd_data == value_q);

	// neighbour sources for the shift up and shift down of the row
	always_comb begin
		up_src[0]     = value_q;
		dn_src[CAP-1] = entries_q[CAP-1];
		for (int i = 1; i < CAP; i++) begin
			up_src[i]   = entries_q[i-1];
			dn_src[i-1] = entries_q[i];
		end
	end

	assign sts.scan_req  = (op_q == pls_pkg::OP_SEARCH) && (count_q != '0);
	assign sts.scan_done = hit || ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// entry row: payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.exec && is_ins && pos_ok_ins && !full) begin
			for (int i = 0; i < CAP; i++) begin
				if (CMP_W'(i) == eff_pos) begin
					entries_q[i] <= value_q;
				end else if (CMP_W'(i) > eff_pos) begin
					entries_q[i] <= up_src[i];
				end
			end
		end else if (cmd.exec && is_rem && pos_ok_rd) begin
			for (int i = 0; i < CAP; i++) begin
				if (CMP_W'(i) >= eff_pos) entries_q[i] <= dn_src[i];
			end
		end
	end

	// command beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= pls_pkg::op_t'(op);
			value_q <= pls_pkg::to_data(value);
			pos_q   <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			rv_q    <= '0;
			fpos_q  <= '0;
			st_q    <= pls_pkg::ST_OK;
		end else if (cmd.exec) begin
			rv_q   <= '0;
			fpos_q <= '0;
			idx_q  <= '0;
			if (is_ins) begin
				if (!pos_ok_ins) begin
					st_q <= pls_pkg::ST_RANGE;
				end else if (full) begin
					st_q <= pls_pkg::ST_FULL;
				end else begin
					st_q    <= pls_pkg::ST_OK;
					count_q <= count_q + CNT_W'(1);
				end
			end else if (is_rem || (op_q == pls_pkg::OP_GET)) begin
				if (!pos_ok_rd) begin
					st_q <= pls_pkg::ST_RANGE;
				end else begin
					st_q <= pls_pkg::ST_OK;
					rv_q <= pls_pkg::from_data(rd_data);
					if (is_rem) count_q <= count_q - CNT_W'(1);
				end
			end else begin
				st_q <= (count_q == '0) ? pls_pkg::ST_RANGE : pls_pkg::ST_NOT_FOUND;
			end
		end else if (cmd.scan) begin
			idx_q <= idx_q + IDX_W'(1);
			if (hit) begin
				st_q   <= pls_pkg::ST_OK;
				fpos_q <= 4'(idx_q);
			end
		end
	end

	assign result_value   = rv_q;
	assign found_position = fpos_q;
	assign status         = st_q;
	assign length         = 5'(count_q);
	assign is_empty       = (count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAP))
		else $error("entry count above capacity");

	a_count_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count moved outside an execute cycle");

endmodule

FILE: hdl/positional_list_store_top.sv
// top level of the positional list store
// depends on pls_pkg, pls_ctrl and pls_dp
`timescale 1ns / 1ps

// Ordered list of up to sixteen signed 32-bit entries with insert, remove,
// search and get by position. A command beat is taken on a clock edge with
// start high and busy low; busy then stays high until the result has been
// shown. The result appears for exactly one cycle with done high and must be
// taken in that cycle, as the result registers hold it only until the next
// command executes. Insert, remove and get pass through an execute state,
// acting on the shifting row of entry registers, then a result state. A
// search walks the row through its single read port one entry a cycle and
// stops at the first match or at the last entry, so it compares at most
// as many entries as the list holds. Busy only drops in the cycle after
// the result, so the next command can be taken at the earliest on the
// edge that ends that idle cycle. Status, length and the empty flag stay
// on the ports between results and show the last outcome.

module positional_list_store_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [4:0]         position,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic [3:0]         found_position,
	output logic [1:0]         status,
	output logic [4:0]         length,
	output logic               is_empty
);

	// command and status between the sequencer and the entry row
	pls_pkg::cmd_t cmd;
	pls_pkg::sts_t sts;

	// sequencer: capture, execute, scan for search, result strobe
	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// entry row, count and result registers
	pls_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.value          (value),
		.position       (position),
		.result_value   (result_value),
		.found_position (found_position),
		.status         (status),
		.length         (length),
		.is_empty       (is_empty)
	);

endmodule

FILE: tb/sv/positional_list_store_top_tb.sv
// self-checking testbench for the positional list store: directed and random command beats
// depends on pls_pkg and positional_list_store_top
`timescale 1ns / 1ps

module positional_list_store_top_tb;

	// cycles with no beat on either side before the run is called hung
	localparam int QUIET_LIMIT = 1000;
	// quiet cycles allowed after the last result before the verdict
	localparam int TAIL_CYCLES = 25;

	// one command beat as queued for the driver
	typedef struct {
		pls_pkg::op_t       op;
		logic signed [31:0] arg;
		logic [4:0]         where;
		int                 gap;   // idle cycles before the beat is offered
		bit                 drain; // hold the beat until every result is back
	} list_cmd_t;

	// what the block should report for one command
	typedef struct {
		logic signed [31:0] rv;
		logic [3:0]         fpos;
		pls_pkg::status_t   st;
		logic [4:0]         len;
		logic               empty;
	} list_outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	pls_pkg::op_t       op = pls_pkg::OP_INS_HEAD;
	logic signed [31:0] value = '0;
	logic [4:0]         position = '0;
	logic               done;
	logic signed [31:0] result_value;
	logic [3:0]         found_position;
	logic [1:0]         status;
	logic [4:0]         length;
	logic               is_empty;

	list_cmd_t     cmd_q[$];
	list_outcome_t outcome_q[$];

	// shadow copy of the list contents
	pls_pkg::data_t shadow_row[pls_pkg::CAPACITY];
	int             shadow_len;

	int n_issued;
	int n_returned;
	int total_cmds;
	int errors;
	int quiet_cycles;
	int st_hits[4];
	int n_reached_full;
	int n_reached_empty;

	// driver-private
	list_cmd_t cur_cmd;
	bit        staged;
	bit        took;
	int        gap_left;

	positional_list_store_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.value          (value),
		.position       (position),
		.done           (done),
		.result_value   (result_value),
		.found_position (found_position),
		.status         (status),
		.length         (length),
		.is_empty       (is_empty)
	);

	always #5 clk = ~clk;

	// applies one command to the shadow list and works out the expected result
	function automatic list_outcome_t apply_list_op(input pls_pkg::op_t code,
			input logic signed [31:0] arg, input logic [4:0] where);
		pls_pkg::data_t d;
		int             p;
		int             i;
		list_outcome_t  r;
		d = pls_pkg::data_t'(arg);
		p = where;
		r.rv = '0;
		r.fpos = '0;
		r.st = pls_pkg::ST_OK;
		case (code)
			pls_pkg::OP_INS_HEAD, pls_pkg::OP_INS_TAIL, pls_pkg::OP_INS_AT: begin
				if (code == pls_pkg::OP_INS_HEAD)
					p = 0;
				else if (code == pls_pkg::OP_INS_TAIL)
					p = shadow_len;
				// the position check wins over the full check
				if (p > shadow_len)
					r.st = pls_pkg::ST_RANGE;
				else if (shadow_len >= pls_pkg::CAPACITY)
					r.st = pls_pkg::ST_FULL;
				else begin
					for (i = shadow_len; i > p; i--)
						shadow_row[i] = shadow_row[i-1];
					shadow_row[p] = d;
					shadow_len++;
					if (shadow_len == pls_pkg::CAPACITY)
						n_reached_full++;
				end
			end
			pls_pkg::OP_REM_HEAD, pls_pkg::OP_REM_TAIL, pls_pkg::OP_REM_AT: begin
				if (code == pls_pkg::OP_REM_HEAD)
					p = 0;
				else if (code == pls_pkg::OP_REM_TAIL)
					p = shadow_len - 1;
				if (shadow_len == 0 || p >= shadow_len)
					r.st = pls_pkg::ST_RANGE;
				else begin
					r.rv = shadow_row[p];
					for (i = p; i + 1 < shadow_len; i++)
						shadow_row[i] = shadow_row[i+1];
					shadow_len--;
					if (shadow_len == 0)
						n_reached_empty++;
				end
			end
			pls_pkg::OP_SEARCH: begin
				if (shadow_len == 0)
					r.st = pls_pkg::ST_RANGE;
				else begin
					r.st = pls_pkg::ST_NOT_FOUND;
					for (i = 0; i < shadow_len; i++) begin
						if (r.st == pls_pkg::ST_NOT_FOUND && shadow_row[i] == d) begin
							r.st = pls_pkg::ST_OK;
							r.fpos = i[3:0];
						end
					end
				end
			end
			default: begin
				if (p >= shadow_len)
					r.st = pls_pkg::ST_RANGE;
				else
					r.rv = shadow_row[p];
			end
		endcase
		r.len = shadow_len[4:0];
		r.empty = (shadow_len == 0);
		st_hits[r.st]++;
		return r;
	endfunction

	task automatic queue_cmd(input pls_pkg::op_t code, input logic signed [31:0] arg,
			input logic [4:0] where, input int gap = 0, input bit drain = 1'b0);
		list_cmd_t c;
		c.op = code;
		c.arg = arg;
		c.where = where;
		c.gap = gap;
		c.drain = drain;
		cmd_q.push_back(c);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (errors < 30)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	// driver: offers queued beats, predicts each one on the edge that takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			op         <= pls_pkg::OP_INS_HEAD;
			value      <= '0;
			position   <= '0;
			n_issued   <= 0;
			staged     = 1'b0;
			gap_left   = 0;
			shadow_len = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				outcome_q.push_back(apply_list_op(op, value, position));
				n_issued <= n_issued + 1;
			end
			// a beat still waiting on busy keeps start and its fields as they are
			if (!start || took) begin
				if (!staged && cmd_q.size() > 0) begin
					cur_cmd  = cmd_q.pop_front();
					staged   = 1'b1;
					gap_left = cur_cmd.gap;
				end
				if (staged && gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (staged && (!cur_cmd.drain ||
						(!took && n_issued == n_returned))) begin
					start    <= 1'b1;
					op       <= cur_cmd.op;
					value    <= cur_cmd.arg;
					position <= cur_cmd.where;
					staged   = 1'b0;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor: every done beat is checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		list_outcome_t want;
		if (!arst_n)
			n_returned <= 0;
		else if (done) begin
			if (outcome_q.size() == 0) begin
				if (errors < 30)
					$display("%0t: result beat with nothing expected, actual status %0d",
						$time, status);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (result_value !== want.rv)
					report_mismatch("result_value", want.rv, result_value);
				if (found_position !== want.fpos)
					report_mismatch("found_position", 32'(want.fpos), 32'(found_position));
				if (status !== want.st)
					report_mismatch("status", 32'(want.st), 32'(status));
				if (length !== want.len)
					report_mismatch("length", 32'(want.len), 32'(length));
				if (is_empty !== want.empty)
					report_mismatch("is_empty", 32'(want.empty), 32'(is_empty));
				n_returned <= n_returned + 1;
			end
		end
	end

	// watchdog on cycles with no beat either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d of %0d commands taken",
				$time, QUIET_LIMIT, n_issued, total_cmds);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int                 rnd;
		int                 k;
		int                 sel;
		int                 gap;
		bit                 idle_on;
		pls_pkg::op_t       code;
		logic signed [31:0] val;
		logic [4:0]         pos;

		// empty list: every remove, search and get must report the range error
		queue_cmd(pls_pkg::OP_REM_HEAD, 32'sd0, 5'd0);
		queue_cmd(pls_pkg::OP_REM_TAIL, 32'sd0, 5'd0);
		queue_cmd(pls_pkg::OP_REM_AT, 32'sd0, 5'd0);
		queue_cmd(pls_pkg::OP_SEARCH, 32'sd0, 5'd0);
		queue_cmd(pls_pkg::OP_GET, 32'sd0, 5'd16);
		// insert past the length of an empty list
		queue_cmd(pls_pkg::OP_INS_AT, 32'sd9, 5'd1);
		// value extremes, insert in the middle and at the length (append)
		queue_cmd(pls_pkg::OP_INS_HEAD, 32'sh8000_0000, 5'd0);
		queue_cmd(pls_pkg::OP_INS_TAIL, 32'sh7fff_ffff, 5'd0, 3);
		queue_cmd(pls_pkg::OP_INS_AT, 32'sd0, 5'd1);
		queue_cmd(pls_pkg::OP_INS_AT, -32'sd1, 5'd3);
		queue_cmd(pls_pkg::OP_INS_AT, 32'sd1, 5'd16);
		// reads inside and just past the end
		queue_cmd(pls_pkg::OP_GET, 32'sd0, 5'd3);
		queue_cmd(pls_pkg::OP_GET, 32'sd0, 5'd4, 2);
		// search hit, miss, and a hit on the last entry
		queue_cmd(pls_pkg::OP_SEARCH, 32'sh7fff_ffff, 5'd0);
		queue_cmd(pls_pkg::OP_SEARCH, 32'sd12345, 5'd0);
		queue_cmd(pls_pkg::OP_SEARCH, -32'sd1, 5'd0);
		// removes from the middle, past the end, both ends, down to empty
		queue_cmd(pls_pkg::OP_REM_AT, 32'sd0, 5'd1);
		queue_cmd(pls_pkg::OP_REM_AT, 32'sd0, 5'd3);
		queue_cmd(pls_pkg::OP_REM_TAIL, 32'sd0, 5'd0);
		queue_cmd(pls_pkg::OP_REM_HEAD, 32'sd0, 5'd0, 5);
		queue_cmd(pls_pkg::OP_REM_AT, 32'sd0, 5'd0);

		// random rounds: fill-heavy, mixed, then drain-heavy, so that the list
		// keeps passing through full and empty; the last round has no idling
		for (rnd = 0; rnd < 7; rnd++) begin
			idle_on = (rnd < 6) && (rnd != 2);
			for (k = 0; k < 80; k++) begin
				sel = $urandom_range(0, 99);
				if (k < 35)
					code = (sel < 75) ? pls_pkg::op_t'($urandom_range(0, 2)) :
						pls_pkg::op_t'($urandom_range(3, 7));
				else if (k < 45)
					code = pls_pkg::op_t'($urandom_range(0, 7));
				else
					code = (sel < 65) ? pls_pkg::op_t'($urandom_range(3, 5)) :
						pls_pkg::op_t'($urandom_range(0, 7));
				// a small pool of values keeps search hits and duplicates common
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 7))
						0: val = 32'sh8000_0000;
						1: val = 32'sh7fff_ffff;
						2: val = 32'sd0;
						3: val = -32'sd1;
						4: val = 32'sd1;
						5: val = 32'sd5;
						6: val = -32'sd100;
						default: val = 32'sh5555_aaaa;
					endcase
				end else
					val = $urandom;
				pos = $urandom_range(0, 1) ? 5'($urandom_range(0, 16)) :
					5'($urandom_range(0, 3));
				gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
				// each round opens only once every earlier result is back
				queue_cmd(code, val, pos, gap, k == 0);
			end
		end
		total_cmds = cmd_q.size();

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(n_issued == total_cmds && n_returned == n_issued))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d commands checked: %0d ok, %0d empty or out of range,",
			n_returned, st_hits[pls_pkg::ST_OK], st_hits[pls_pkg::ST_RANGE]);
		$display("%0d not found, %0d full; list filled to capacity %0d times, emptied %0d times",
			st_hits[pls_pkg::ST_NOT_FOUND], st_hits[pls_pkg::ST_FULL],
			n_reached_full, n_reached_empty);
		if (errors == 0 && outcome_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
